// ===== src/tmd_pkg.sv =====
// shared types and constants for the primitive packet decoder
// no dependencies
package tmd_pkg;

  localparam int unsigned MaxPacketWords = 32;
  localparam int unsigned MaxVertices    = 8192;
  localparam int unsigned LenW           = 6;
  localparam int unsigned CntW           = 14;
  localparam int unsigned VertW          = 13;

  localparam logic [1:0] KIND_UNTEX  = 2'd0;
  localparam logic [1:0] KIND_TEX    = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [0:0] REG_PRIM_COUNT   = 1'b1;

  localparam logic [23:0] Grey = 24'h808080;

  // packet classes decided by the front part
  typedef enum logic [3:0] {
    PK_NONE,
    PK_F3,
    PK_F3B,
    PK_G3,
    PK_FT3,
    PK_FT3B,
    PK_GT3,
    PK_GT3B,
    PK_F4,
    PK_G4,
    PK_ERR
  } pkind_e;

  // one finished packet handed from front to back
  typedef struct packed {
    pkind_e            pk;
    logic              obj_end;
    logic [7:0][31:0]  words;
  } job_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] va, vb, vc;
    logic [23:0] ca, cb, cc;
    logic [15:0] ta, tb, tc;
    logic [31:0] pp;
    logic        last;
  } res_t;

endpackage

// ===== src/tmd_front.sv =====
// front part: header parse, payload capture, packet classification
// depends on tmd_pkg
module tmd_front import tmd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [31:0]     word_i,
  input  logic [CntW-1:0] prim_count_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output job_t            job_o
);

  logic [LenW-1:0]  len_q, len_d;
  logic [7:0]       flag_q, mode_q;
  logic [LenW-1:0]  pos_q;
  logic [CntW-1:0]  seen_q, seen_d;
  logic             halted_q;
  logic [7:0][31:0] words_q;

  logic [7:0]  hlen;
  logic        fire, is_hdr, bad, done;
  logic [CntW-1:0] lim, seen_inc;
  pkind_e      cls;

  // block only when the queue is full; halted swallows every word
  assign ready_o = halted_q || job_ready_i;
  assign fire    = valid_i && ready_o && !halted_q;
  assign is_hdr  = (len_q == '0);
  assign hlen    = word_i[15:8];
  assign bad     = (hlen == 8'd0) || (hlen > 8'(MaxPacketWords));
  assign done    = !is_hdr && ((pos_q + 1'b1) == len_q);
  assign lim      = (prim_count_i == '0) ? CntW'(1) : prim_count_i;
  assign seen_inc = seen_q + 1'b1;

  always_comb begin
    cls = PK_NONE;
    priority if (mode_q == 8'h20 && flag_q == 8'd0 && len_q == 6'd3) cls = PK_F3;
    else if (mode_q == 8'h30 && flag_q == 8'd0 && len_q == 6'd4) cls = PK_F3B;
    else if (mode_q == 8'h30 && flag_q == 8'd0 && len_q == 6'd6) cls = PK_G3;
    else if (mode_q == 8'h24 && flag_q == 8'd0 && len_q == 6'd5) cls = PK_FT3;
    else if (mode_q == 8'h34 && flag_q == 8'd0 && len_q == 6'd6) cls = PK_FT3B;
    else if (mode_q == 8'h25 && flag_q == 8'd1 && len_q == 6'd6) cls = PK_GT3;
    else if (mode_q == 8'h35 && flag_q == 8'd1 && len_q == 6'd8) cls = PK_GT3B;
    else if (mode_q == 8'h28 && flag_q == 8'd0 && len_q == 6'd4) cls = PK_F4;
    else if (mode_q == 8'h28 && flag_q == 8'd4 && len_q == 6'd7) cls = PK_G4;
    else cls = PK_NONE;
  end

  always_comb begin
    len_d  = len_q;
    seen_d = seen_q;
    job_valid_o  = 1'b0;
    job_o.pk     = cls;
    job_o.obj_end = (seen_inc >= lim);
    job_o.words  = words_q;
    if (pos_q < 6'd8) job_o.words[pos_q[2:0]] = word_i;
    if (fire) begin
      if (is_hdr) begin
        if (bad) begin
          job_valid_o = 1'b1;
          job_o.pk    = PK_ERR;
          job_o.obj_end = 1'b0;
        end else begin
          len_d = hlen[LenW-1:0];
        end
      end else if (done) begin
        len_d = '0;
        seen_d = job_o.obj_end ? '0 : seen_inc;
        job_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      flag_q   <= '0;
      mode_q   <= '0;
      pos_q    <= '0;
      seen_q   <= '0;
      halted_q <= 1'b0;
    end else if (fire) begin
      len_q  <= len_d;
      seen_q <= seen_d;
      if (is_hdr) begin
        halted_q <= bad;
        flag_q   <= word_i[23:16];
        mode_q   <= word_i[31:24];
        pos_q    <= '0;
      end else begin
        pos_q <= done ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !is_hdr && pos_q < 6'd8) words_q[pos_q[2:0]] <= word_i;
  end

endmodule

// ===== src/tmd_queue.sv =====
// two-entry job queue between front and back
// depends on tmd_pkg
module tmd_queue import tmd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_o
);

  job_t      mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_i;
  end

endmodule

// ===== src/tmd_back.sv =====
// back part: triangle assembly, vertex checks, result sequencing
// depends on tmd_pkg
module tmd_back import tmd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  job_t            job_i,
  input  logic [CntW-1:0] vertex_count_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output res_t            res_o
);

  logic [1:0] step_q;   // results already sent for head job
  res_t       r0, r1, r2, sel;
  logic [1:0] n;
  logic [CntW-1:0] lim;
  logic       out_v_q;
  res_t       out_q;
  logic       take, adv, done;

  function automatic logic [7:0] pb(input logic [7:0][31:0] w, input int k);
    logic [2:0] wi;
    logic [4:0] bi;
    wi = 3'(k >> 2);
    bi = 5'((k % 4) * 8);
    return w[wi][bi +: 8];
  endfunction
  function automatic logic [15:0] ph(input logic [7:0][31:0] w, input int k);
    return {pb(w, k+1), pb(w, k)};
  endfunction
  function automatic logic [23:0] pc(input logic [7:0][31:0] w, input int k);
    return {pb(w, k+2), pb(w, k+1), pb(w, k)};
  endfunction

  assign lim = (vertex_count_i > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vertex_count_i;

  function automatic logic ok(input logic [15:0] i, input logic [CntW-1:0] l);
    return {2'b0, i} < {4'b0, l};
  endfunction

  function automatic res_t mk_tri(input logic [1:0] k, input logic [15:0] i0, i1, i2,
                                  input logic [23:0] c0, c1, c2,
                                  input logic [15:0] t0, t1, t2, input logic [31:0] pp);
    res_t r;
    r.kind = k; r.va = i0[12:0]; r.vb = i2[12:0]; r.vc = i1[12:0];
    r.ca = c0; r.cb = c2; r.cc = c1; r.ta = t0; r.tb = t2; r.tc = t1;
    r.pp = pp; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [7:0][31:0] w;
    logic [15:0] i0, i1, i2, i3, o0, o1, o2;
    logic [23:0] c;
    logic tex, v3, v4;
    res_t er;
    w = job_i.words;
    er = '0;
    r0 = '0; r1 = '0; r2 = '0; n = 2'd0;
    c = pc(w, 0);
    i0 = '0; i1 = '0; i2 = '0; i3 = '0; o0 = '0; o1 = '0; o2 = '0;
    tex = 1'b0;
    unique case (job_i.pk)
      PK_F3:   begin i0 = ph(w, 6);  i1 = ph(w, 8);  i2 = ph(w, 10); end
      PK_F3B:  begin i0 = ph(w, 6);  i1 = ph(w, 10); i2 = ph(w, 14); end
      PK_G3:   begin i0 = ph(w, 14); i1 = ph(w, 18); i2 = ph(w, 22); end
      PK_FT3:  begin i0 = ph(w, 14); i1 = ph(w, 16); i2 = ph(w, 18); tex = 1'b1; end
      PK_FT3B: begin i0 = ph(w, 14); i1 = ph(w, 18); i2 = ph(w, 22); tex = 1'b1; end
      PK_GT3:  begin i0 = ph(w, 16); i1 = ph(w, 18); i2 = ph(w, 20); tex = 1'b1; end
      PK_GT3B: begin i0 = ph(w, 24); i1 = ph(w, 26); i2 = ph(w, 28); tex = 1'b1; end
      PK_F4:   begin i0 = ph(w, 6);  i1 = ph(w, 8);  i2 = ph(w, 10); i3 = ph(w, 12); end
      PK_G4:   begin i0 = ph(w, 18); i1 = ph(w, 20); i2 = ph(w, 22); i3 = ph(w, 24); end
      default: begin end
    endcase
    v3 = ok(i0, lim) && ok(i1, lim) && ok(i2, lim);
    v4 = v3 && ok(i3, lim);
    unique case (job_i.pk)
      PK_F3, PK_F3B: if (v3) begin
        r0 = mk_tri(KIND_UNTEX, i0, i1, i2, c, c, c, '0, '0, '0, '0); n = 2'd1;
      end
      PK_G3: if (v3) begin
        r0 = mk_tri(KIND_UNTEX, i0, i1, i2, pc(w, 0), pc(w, 4), pc(w, 8), '0, '0, '0, '0);
        n = 2'd1;
      end
      PK_FT3, PK_FT3B, PK_GT3, PK_GT3B: if (v3 && tex) begin
        r0 = mk_tri(KIND_TEX, i0, i1, i2, Grey, Grey, Grey, ph(w, 0), ph(w, 4), ph(w, 8),
                    {ph(w, 6), ph(w, 2)});
        n = 2'd1;
      end
      PK_F4: if (v4) begin
        r0 = mk_tri(KIND_UNTEX, i0, i1, i2, c, c, c, '0, '0, '0, '0);
        r1 = mk_tri(KIND_UNTEX, i1, i3, i2, c, c, c, '0, '0, '0, '0); n = 2'd2;
      end
      PK_G4: if (v4) begin
        r0 = mk_tri(KIND_UNTEX, i0, i1, i2, pc(w, 0), pc(w, 4), pc(w, 8), '0, '0, '0, '0);
        r1 = mk_tri(KIND_UNTEX, i1, i3, i2, pc(w, 4), pc(w, 12), pc(w, 8), '0, '0, '0, '0);
        n = 2'd2;
      end
      PK_ERR: begin
        er.kind = KIND_ERROR; r0 = er; n = 2'd1;
      end
      default: begin end
    endcase
    if (job_i.obj_end) begin
      er = '0; er.kind = KIND_END;
      unique case (n)
        2'd0: r0 = er;
        2'd1: r1 = er;
        default: r2 = er;
      endcase
      n = n + 2'd1;
    end
    unique case (step_q)
      2'd0: sel = r0;
      2'd1: sel = r1;
      default: sel = r2;
    endcase
    sel.last = (step_q + 2'd1 == n);
  end

  // free output slot or the slot drains this cycle
  assign take = !out_v_q || res_ready_i;
  assign adv  = job_valid_i && take;
  assign done = (n == 2'd0) || (step_q + 2'd1 >= n);
  assign job_ready_o = adv && done;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (take) out_v_q <= adv && (n != 2'd0);
      if (adv) step_q <= done ? 2'd0 : step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= sel;
  end

endmodule

// ===== src/tmd_primitive_packet_decoder.sv =====
// primitive packet decoder: one stream word accepted per cycle while the queue has room,
// results one per cycle while the receiver is ready; after its final word, a packet's
// results pass through the job queue and then the output register; a quad or an object
// end holds its back job for each extra result, absorbed by the two-entry job queue
// reset: asynchronous active low, clears parser, packet count, halt flag and queue;
// payload storage is not cleared, registers return to vertex_count 1 and prim_count 1
module tmd_primitive_packet_decoder import tmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        stream_word_valid_i,
  output logic        stream_word_ready_o,
  input  logic [31:0] stream_word_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [1:0]  kind_o,
  output logic [12:0] vert_a_o,
  output logic [12:0] vert_b_o,
  output logic [12:0] vert_c_o,
  output logic [23:0] color_a_o,
  output logic [23:0] color_b_o,
  output logic [23:0] color_c_o,
  output logic [15:0] texcoord_a_o,
  output logic [15:0] texcoord_b_o,
  output logic [15:0] texcoord_c_o,
  output logic [31:0] page_and_palette_o,
  output logic        last_o
);

  logic [CntW-1:0] vcount_q, pcount_q;

  // configuration registers, written directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CntW'(1);
      pcount_q <= CntW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VERTEX_COUNT: vcount_q <= cfg_data_i;
        default:          pcount_q <= cfg_data_i;
      endcase
    end
  end

  logic job_v, job_r, q_v, q_r;
  job_t job, qjob;
  res_t res;

  // front: parses headers and buffers payload words
  tmd_front u_front (
    .clk_i, .rst_ni,
    .valid_i(stream_word_valid_i), .ready_o(stream_word_ready_o), .word_i(stream_word_i),
    .prim_count_i(pcount_q),
    .job_valid_o(job_v), .job_ready_i(job_r), .job_o(job)
  );

  // decoupling queue
  tmd_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(job_v), .in_ready_o(job_r), .in_i(job),
    .out_valid_o(q_v), .out_ready_i(q_r), .out_o(qjob)
  );

  // back: builds triangles and sequences results
  tmd_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_v), .job_ready_o(q_r), .job_i(qjob),
    .vertex_count_i(vcount_q),
    .res_valid_o(result_valid_o), .res_ready_i(result_ready_i), .res_o(res)
  );

  assign kind_o             = res.kind;
  assign vert_a_o           = res.va;
  assign vert_b_o           = res.vb;
  assign vert_c_o           = res.vc;
  assign color_a_o          = res.ca;
  assign color_b_o          = res.cb;
  assign color_c_o          = res.cc;
  assign texcoord_a_o       = res.ta;
  assign texcoord_b_o       = res.tb;
  assign texcoord_c_o       = res.tc;
  assign page_and_palette_o = res.pp;
  assign last_o             = res.last;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the primitive packet decoder
// depends on tmd_pkg and tmd_primitive_packet_decoder
`timescale 1ns / 1ps

module testbench;
  import tmd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        stream_word_valid_i;
  logic        stream_word_ready_o;
  logic [31:0] stream_word_i;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [13:0] cfg_data_i;
  logic        result_valid_o;
  logic        result_ready_i;
  logic [1:0]  kind_o;
  logic [12:0] vert_a_o, vert_b_o, vert_c_o;
  logic [23:0] color_a_o, color_b_o, color_c_o;
  logic [15:0] texcoord_a_o, texcoord_b_o, texcoord_c_o;
  logic [31:0] page_and_palette_o;
  logic        last_o;

  tmd_primitive_packet_decoder u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .stream_word_valid_i (stream_word_valid_i),
    .stream_word_ready_o (stream_word_ready_o),
    .stream_word_i       (stream_word_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .result_ready_i      (result_ready_i),
    .kind_o              (kind_o),
    .vert_a_o            (vert_a_o),
    .vert_b_o            (vert_b_o),
    .vert_c_o            (vert_c_o),
    .color_a_o           (color_a_o),
    .color_b_o           (color_b_o),
    .color_c_o           (color_c_o),
    .texcoord_a_o        (texcoord_a_o),
    .texcoord_b_o        (texcoord_b_o),
    .texcoord_c_o        (texcoord_c_o),
    .page_and_palette_o  (page_and_palette_o),
    .last_o              (last_o)
  );

  // packet header modes of the known kinds
  localparam logic [7:0] MODE_F3  = 8'h20;
  localparam logic [7:0] MODE_F3B = 8'h30;
  localparam logic [7:0] MODE_FT3 = 8'h24;
  localparam logic [7:0] MODE_FT3B = 8'h34;
  localparam logic [7:0] MODE_GT3 = 8'h25;
  localparam logic [7:0] MODE_GT3B = 8'h35;
  localparam logic [7:0] MODE_QUAD = 8'h28;
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned SettleCycles  = 20;

  // decoder shadow state
  logic [31:0] shadow_payload [MaxPacketWords];
  logic [5:0]  shadow_len;
  logic [7:0]  shadow_flag;
  logic [7:0]  shadow_mode;
  logic [5:0]  shadow_pos;
  logic [13:0] shadow_packets;
  logic        shadow_halted;
  logic [13:0] vert_limit_reg;
  logic [13:0] prim_limit_reg;

  res_t        pending_tris [$];   // results of the word being predicted
  res_t        expected_results [$];
  logic [31:0] word_q [$];
  int unsigned fail_count;
  int unsigned cycle_count;

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] pkt_byte(int unsigned k);
    int unsigned w;
    logic [4:0]  bi;
    w = k >> 2;
    bi = 5'((k % 4) * 8);
    if (w >= MaxPacketWords || w >= shadow_len) return 8'h00;
    return shadow_payload[w[4:0]][bi +: 8];
  endfunction

  function automatic logic [15:0] pkt_half(int unsigned k);
    return {pkt_byte(k + 1), pkt_byte(k)};
  endfunction

  function automatic logic [23:0] pkt_color(int unsigned k);
    return {pkt_byte(k + 2), pkt_byte(k + 1), pkt_byte(k)};
  endfunction

  function automatic bit vert_ok(logic [15:0] i);
    int unsigned lim;
    lim = (vert_limit_reg > MaxVertices) ? MaxVertices : vert_limit_reg;
    return i < lim;
  endfunction

  function automatic res_t blank_res(logic [1:0] k);
    res_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // winding swap: (v0,v1,v2) goes out as (v0,v2,v1)
  function automatic void emit_tri(logic [1:0] k, logic [15:0] i0, logic [15:0] i1,
                                   logic [15:0] i2, logic [23:0] c0, logic [23:0] c1,
                                   logic [23:0] c2, logic [15:0] t0, logic [15:0] t1,
                                   logic [15:0] t2, logic [31:0] pp);
    res_t r;
    if (!vert_ok(i0) || !vert_ok(i1) || !vert_ok(i2)) return;
    r = blank_res(k);
    r.va = i0[12:0]; r.vb = i2[12:0]; r.vc = i1[12:0];
    r.ca = c0; r.cb = c2; r.cc = c1;
    r.ta = t0; r.tb = t2; r.tc = t1;
    r.pp = pp;
    pending_tris.push_back(r);
  endfunction

  function automatic void emit_textured(int unsigned o0, int unsigned o1, int unsigned o2);
    emit_tri(KIND_TEX, pkt_half(o0), pkt_half(o1), pkt_half(o2), Grey, Grey, Grey,
             pkt_half(0), pkt_half(4), pkt_half(8), {pkt_half(6), pkt_half(2)});
  endfunction

  function automatic void emit_quad(logic [15:0] i0, logic [15:0] i1, logic [15:0] i2,
                                    logic [15:0] i3, logic [23:0] c0, logic [23:0] c1,
                                    logic [23:0] c2, logic [23:0] c3);
    // one bad corner drops both halves
    if (!vert_ok(i0) || !vert_ok(i1) || !vert_ok(i2) || !vert_ok(i3)) return;
    emit_tri(KIND_UNTEX, i0, i1, i2, c0, c1, c2, '0, '0, '0, '0);
    emit_tri(KIND_UNTEX, i1, i3, i2, c1, c3, c2, '0, '0, '0, '0);
  endfunction

  function automatic void decode_packet();
    logic [7:0]  m, f;
    logic [5:0]  l;
    logic [23:0] c;
    m = shadow_mode; f = shadow_flag; l = shadow_len;
    c = pkt_color(0);
    if (m == MODE_F3 && f == 0 && l == 3)
      emit_tri(KIND_UNTEX, pkt_half(6), pkt_half(8), pkt_half(10), c, c, c, '0, '0, '0, '0);
    else if (m == MODE_F3B && f == 0 && l == 4)
      emit_tri(KIND_UNTEX, pkt_half(6), pkt_half(10), pkt_half(14), c, c, c,
               '0, '0, '0, '0);
    else if (m == MODE_F3B && f == 0 && l == 6)
      emit_tri(KIND_UNTEX, pkt_half(14), pkt_half(18), pkt_half(22),
               pkt_color(0), pkt_color(4), pkt_color(8), '0, '0, '0, '0);
    else if (m == MODE_FT3 && f == 0 && l == 5) emit_textured(14, 16, 18);
    else if (m == MODE_FT3B && f == 0 && l == 6) emit_textured(14, 18, 22);
    else if (m == MODE_GT3 && f == 1 && l == 6) emit_textured(16, 18, 20);
    else if (m == MODE_GT3B && f == 1 && l == 8) emit_textured(24, 26, 28);
    else if (m == MODE_QUAD && f == 0 && l == 4)
      emit_quad(pkt_half(6), pkt_half(8), pkt_half(10), pkt_half(12), c, c, c, c);
    else if (m == MODE_QUAD && f == 4 && l == 7)
      emit_quad(pkt_half(18), pkt_half(20), pkt_half(22), pkt_half(24),
                pkt_color(0), pkt_color(4), pkt_color(8), pkt_color(12));
  endfunction

  function automatic void predict_word(logic [31:0] w);
    logic [7:0]  len;
    logic [13:0] lim;
    res_t        r;
    pending_tris.delete();
    if (shadow_halted) return;
    if (shadow_len == 0) begin
      len = w[15:8];
      if (len == 0 || len > MaxPacketWords) begin
        // bad length: one error item, then the block goes deaf
        shadow_halted = 1'b1;
        r = blank_res(KIND_ERROR);
        r.last = 1'b1;
        expected_results.push_back(r);
        return;
      end
      shadow_len  = len[5:0];
      shadow_flag = w[23:16];
      shadow_mode = w[31:24];
      shadow_pos  = '0;
      return;
    end
    shadow_payload[shadow_pos[4:0]] = w;
    shadow_pos = shadow_pos + 6'd1;
    if (shadow_pos < shadow_len) return;
    decode_packet();
    shadow_len = '0;
    shadow_pos = '0;
    shadow_packets = shadow_packets + 14'd1;
    lim = (prim_limit_reg == 0) ? 14'd1 : prim_limit_reg;
    if (shadow_packets >= lim) begin
      pending_tris.push_back(blank_res(KIND_END));
      shadow_packets = '0;
    end
    if (pending_tris.size() > 0) pending_tris[pending_tris.size() - 1].last = 1'b1;
    foreach (pending_tris[i]) expected_results.push_back(pending_tris[i]);
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- driver
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin
    logic        nxt_valid;
    logic [31:0] nxt_word;
    bit          accepted;
    nxt_valid = stream_word_valid_i;
    nxt_word  = stream_word_i;
    accepted  = stream_word_valid_i && stream_word_ready_o && rst_ni;
    if (accepted) predict_word(stream_word_i);
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!stream_word_valid_i || accepted) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() > 0) begin
        nxt_valid = 1'b1;
        nxt_word  = word_q.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // new burst; sometimes long streaks with no gaps at all
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
    stream_word_valid_i <= nxt_valid;
    stream_word_i       <= nxt_word;
  end

  // ---------------------------------------------------------------- monitor
  int unsigned ready_mode;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && result_valid_o && result_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item, kind %0d", kind_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("kind", 32'(e.kind), 32'(kind_o));
        check_field("vert_a", 32'(e.va), 32'(vert_a_o));
        check_field("vert_b", 32'(e.vb), 32'(vert_b_o));
        check_field("vert_c", 32'(e.vc), 32'(vert_c_o));
        check_field("color_a", 32'(e.ca), 32'(color_a_o));
        check_field("color_b", 32'(e.cb), 32'(color_b_o));
        check_field("color_c", 32'(e.cc), 32'(color_c_o));
        check_field("texcoord_a", 32'(e.ta), 32'(texcoord_a_o));
        check_field("texcoord_b", 32'(e.tb), 32'(texcoord_b_o));
        check_field("texcoord_c", 32'(e.tc), 32'(texcoord_c_o));
        check_field("page_and_palette", e.pp, page_and_palette_o);
        check_field("last", 32'(e.last), 32'(last_o));
      end
    end
    // receiver changes its stall habit, picked at random from four modes
    if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: result_ready_i <= 1'b1;
      1: result_ready_i <= ($urandom_range(0, 1) == 0);
      2: result_ready_i <= ($urandom_range(0, 3) == 0);
      default: result_ready_i <= (cycle_count % 8) < 5;
    endcase
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TimeoutCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // random vertex index, mostly inside the current limit
  function automatic logic [15:0] pick_vertex();
    int unsigned lim;
    lim = (vert_limit_reg > MaxVertices) ? MaxVertices : vert_limit_reg;
    if (lim == 0 || $urandom_range(0, 15) == 0) return 16'($urandom_range(0, 16'hffff));
    if ($urandom_range(0, 7) == 0) return 16'(lim - 1);
    return 16'($urandom_range(0, lim - 1));
  endfunction

  // push one packet; sel picks the kind, anything past the known ones is unknown
  task automatic push_packet(int unsigned sel);
    logic [7:0]  m, f, l;
    logic [31:0] words [MaxPacketWords];
    int unsigned offs [4];
    int unsigned n_idx;
    n_idx = 3;
    case (sel)
      0: begin m = MODE_F3;   f = 8'd0; l = 8'd3; offs = '{6, 8, 10, 0}; end
      1: begin m = MODE_F3B;  f = 8'd0; l = 8'd4; offs = '{6, 10, 14, 0}; end
      2: begin m = MODE_F3B;  f = 8'd0; l = 8'd6; offs = '{14, 18, 22, 0}; end
      3: begin m = MODE_FT3;  f = 8'd0; l = 8'd5; offs = '{14, 16, 18, 0}; end
      4: begin m = MODE_FT3B; f = 8'd0; l = 8'd6; offs = '{14, 18, 22, 0}; end
      5: begin m = MODE_GT3;  f = 8'd1; l = 8'd6; offs = '{16, 18, 20, 0}; end
      6: begin m = MODE_GT3B; f = 8'd1; l = 8'd8; offs = '{24, 26, 28, 0}; end
      7: begin m = MODE_QUAD; f = 8'd0; l = 8'd4; offs = '{6, 8, 10, 12}; n_idx = 4; end
      8: begin m = MODE_QUAD; f = 8'd4; l = 8'd7; offs = '{18, 20, 22, 24}; n_idx = 4; end
      default: begin
        // unknown kind, sometimes a near miss of a known one, sometimes full length
        m = 8'($urandom_range(0, 255));
        f = 8'($urandom_range(0, 7));
        l = ($urandom_range(0, 4) == 0) ? 8'(MaxPacketWords) : 8'($urandom_range(1, 9));
        if ($urandom_range(0, 1) == 0) m = {2'b00, m[5], m[4], 1'b0, m[2:0]} | 8'h20;
        offs = '{0, 0, 0, 0};
        n_idx = 0;
      end
    endcase
    for (int i = 0; i < MaxPacketWords; i++) words[i] = $urandom();
    for (int i = 0; i < n_idx; i++) words[offs[i] / 4][(offs[i] % 4) * 8 +: 16] = pick_vertex();
    word_q.push_back({m, f, l, 8'($urandom_range(0, 255))});
    for (int i = 0; i < l; i++) word_q.push_back(words[i]);
  endtask

  task automatic wait_idle();
    while (word_q.size() > 0 || stream_word_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    // an unknown packet may still be in flight with nothing expected
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [13:0] verts, logic [13:0] prims);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_VERTEX_COUNT;
    cfg_data_i  <= verts;
    vert_limit_reg = verts;
    @(posedge clk_i);
    cfg_index_i <= REG_PRIM_COUNT;
    cfg_data_i  <= prims;
    prim_limit_reg = prims;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(logic [13:0] verts, logic [13:0] prims, int unsigned n_words);
    int unsigned start;
    int unsigned r;
    wait_idle();
    write_regs(verts, prims);
    @(negedge clk_i);
    start = word_q.size();
    while (word_q.size() - start < n_words) begin
      r = $urandom_range(0, 99);
      push_packet(r < 82 ? $urandom_range(0, 8) : 9);
    end
  endtask

  initial begin
    logic [7:0] bad_len;
    rst_ni              = 1'b0;
    stream_word_valid_i = 1'b0;
    stream_word_i       = '0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = REG_VERTEX_COUNT;
    cfg_data_i          = '0;
    result_ready_i      = 1'b0;
    fail_count          = 0;
    cycle_count         = 0;
    burst_left          = 0;
    gap_left            = 0;
    ready_mode          = 0;
    shadow_len          = '0;
    shadow_flag         = '0;
    shadow_mode         = '0;
    shadow_pos          = '0;
    shadow_packets      = '0;
    shadow_halted       = 1'b0;
    vert_limit_reg      = 14'd1;
    prim_limit_reg      = 14'd1;
    foreach (shadow_payload[i]) shadow_payload[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset limits, then a flat triangle, both quads and a textured one
    @(negedge clk_i);
    word_q.push_back({MODE_F3, 8'd0, 8'd3, 8'hff});
    word_q.push_back(32'hffffffff);
    word_q.push_back(32'h0000ffff);
    word_q.push_back(32'h00000000);
    wait_idle();
    write_regs(14'd8192, 14'd3);
    @(negedge clk_i);
    // mono quad at the top index edge
    word_q.push_back({MODE_QUAD, 8'd0, 8'd4, 8'h00});
    word_q.push_back(32'h00123456);
    word_q.push_back(32'h1fff0000);
    word_q.push_back(32'h00001ffe);
    word_q.push_back(32'h00001ffd);
    push_packet(3);
    push_packet(8);
    random_phase(14'd1, 14'd1, 70);
    random_phase(14'd16383, 14'd0, 70);
    random_phase(14'd8192, 14'd8192, 60);
    random_phase(14'($urandom_range(1, 8191)), 14'($urandom_range(1, 8)), 70);
    random_phase(14'd0, 14'd2, 40);
    random_phase(14'($urandom_range(2, 64)), 14'($urandom_range(1, 4)), 80);

    // bad length halts the block; everything after is ignored
    wait_idle();
    @(negedge clk_i);
    bad_len = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(33, 255));
    word_q.push_back({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), bad_len,
                      8'($urandom_range(0, 255))});
    for (int i = 0; i < 6; i++) word_q.push_back($urandom());
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d expected result items never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
